FILE: rtl/evqg_pkg.sv
// ----------------------------------------------------------------------------
// evqg_pkg
// shared types and constants for the ellipse quadrant vertex generator
// ----------------------------------------------------------------------------
package evqg_pkg;

  localparam int INDEX_W          = 11;
  localparam int DEF_RADIUS_BITS  = 10;
  localparam int DEF_FRAC_BITS    = 6;
  localparam int CFG_INDEX_W      = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS_X     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS_Y     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUADRANT_SEL = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLOSING_KIND = 2'd3;

  // per-vertex tag that travels down the chain
  typedef struct packed {
    logic is_sample;
    logic is_last;
    logic oor;
  } meta_t;

endpackage

FILE: rtl/evqg_sqrt_cell.sv
// ----------------------------------------------------------------------------
// evqg_sqrt_cell
// one root bit of a pipelined integer square root
// ----------------------------------------------------------------------------
module evqg_sqrt_cell
  import evqg_pkg::*;
#(
  parameter int SQ_W  = 16,
  parameter int RAD_W = 32,
  parameter int X_W   = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  meta_t              meta_i,
  input  logic [X_W-1:0]     x_i,
  input  logic [SQ_W+1:0]    rem_i,
  input  logic [SQ_W-1:0]    root_i,
  input  logic [RAD_W-1:0]   rad_i,
  output logic               valid_o,
  output meta_t              meta_o,
  output logic [X_W-1:0]     x_o,
  output logic [SQ_W+1:0]    rem_o,
  output logic [SQ_W-1:0]    root_o,
  output logic [RAD_W-1:0]   rad_o
);

  logic [SQ_W+1:0] rem_sh;
  logic [SQ_W+1:0] trial;
  logic            ge;

  assign rem_sh = {rem_i[SQ_W-1:0], rad_i[RAD_W-1 -: 2]};
  assign trial  = {root_i, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_o <= meta_i;
      x_o    <= x_i;
      rem_o  <= ge ? (rem_sh - trial) : rem_sh;
      root_o <= {root_i[SQ_W-2:0], ge};
      rad_o  <= rad_i << 2;
    end
  end

endmodule

FILE: rtl/evqg_div_cell.sv
// ----------------------------------------------------------------------------
// evqg_div_cell
// one quotient bit of a pipelined restoring divider
// ----------------------------------------------------------------------------
module evqg_div_cell
  import evqg_pkg::*;
#(
  parameter int RB_W = 10,
  parameter int Q_W  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [RB_W-1:0]  divisor,
  input  logic             valid_i,
  input  meta_t            meta_i,
  input  logic [RB_W-1:0]  x_i,
  input  logic [RB_W-1:0]  rem_i,
  input  logic [Q_W-1:0]   low_i,
  input  logic [Q_W-1:0]   quot_i,
  output logic             valid_o,
  output meta_t            meta_o,
  output logic [RB_W-1:0]  x_o,
  output logic [RB_W-1:0]  rem_o,
  output logic [Q_W-1:0]   low_o,
  output logic [Q_W-1:0]   quot_o
);

  logic [RB_W:0] t;
  logic [RB_W:0] diff;
  logic          ge;

  assign t    = {rem_i, low_i[Q_W-1]};
  assign ge   = (t >= {1'b0, divisor});
  assign diff = t - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_o <= meta_i;
      x_o    <= x_i;
      rem_o  <= ge ? diff[RB_W-1:0] : t[RB_W-1:0];
      low_o  <= low_i << 1;
      quot_o <= {quot_i[Q_W-2:0], ge};
    end
  end

endmodule

FILE: rtl/ellipse_quadrant_vertex_gen.sv
// ----------------------------------------------------------------------------
// ellipse_quadrant_vertex_gen
// vertex generator for one sampled quarter of an ellipse
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_stall carries a vertex index; one output
//   transaction per input transaction on out_valid/out_stall with x_coord,
//   y_fixed, is_last and out_of_range, in order.
//   stages: index decode, x square, square-root cells, radius_y multiply,
//   divider cells, output register. throughput one vertex per cycle when not
//   stalled, set by the square-root and divider cell chains that each take
//   one bit per cycle. the whole chain moves as one; when the receiver stalls
//   a waiting result, the chain holds and in_stall rises until the result is
//   taken. reset clears all valid bits and loads radius 1/1, upper-right
//   quadrant, fan closing. cfg_we writes register cfg_index with cfg_data;
//   the user must make writes only while the chain is empty; no check enforces it.
// ----------------------------------------------------------------------------
module ellipse_quadrant_vertex_gen
  import evqg_pkg::*;
#(
  parameter int RADIUS_BITS = DEF_RADIUS_BITS,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [CFG_INDEX_W-1:0]               cfg_index,
  input  logic [RADIUS_BITS-1:0]               cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [INDEX_W-1:0]                   in_vertex_index,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [RADIUS_BITS:0]          out_x_coord,
  output logic signed [RADIUS_BITS+FRAC_BITS:0] out_y_fixed,
  output logic                                 out_is_last,
  output logic                                 out_out_of_range
);

  localparam int RB    = RADIUS_BITS;
  localparam int XW    = RB + 1;
  localparam int YW    = RB + FRAC_BITS + 1;
  localparam int SQ    = RB + FRAC_BITS;      // root width, also quotient width
  localparam int RADW  = 2 * SQ;
  localparam int PW    = RB + SQ;
  localparam int CW    = (INDEX_W > RB + 2) ? INDEX_W : RB + 2;

  // configuration registers
  logic [RB-1:0]   rx_r, ry_r;
  logic            quad_r, close_r;
  logic [2*RB-1:0] rx_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r    <= RB'(1);
      ry_r    <= RB'(1);
      quad_r  <= 1'b0;
      close_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIUS_X:     rx_r    <= cfg_data;
        CFG_RADIUS_Y:     ry_r    <= cfg_data;
        CFG_QUADRANT_SEL: quad_r  <= cfg_data[0];
        CFG_CLOSING_KIND: close_r <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // rx squared is registered, following the register in the cycle after it changes
  always_ff @(posedge clk) begin
    rx_sq_r <= rx_r * rx_r;
  end

  // single advance enable for the whole chain
  logic out_valid_r;
  logic en;
  assign in_stall = out_valid_r & out_stall;
  assign en       = ~in_stall;

  // stage a: decode the index
  logic [CW-1:0] k_ext, rx1, rx2;
  meta_t         a_meta_nxt;
  logic [RB-1:0] a_x_nxt;
  logic          a_valid_r;
  meta_t         a_meta_r;
  logic [RB-1:0] a_x_r;

  assign k_ext = CW'(in_vertex_index);
  assign rx1   = CW'(rx_r) + CW'(1);
  assign rx2   = CW'(rx_r) + CW'(2);

  always_comb begin
    a_meta_nxt = '0;
    a_x_nxt    = '0;
    if (k_ext == '0) begin
      // origin
    end else if (k_ext <= rx1) begin
      a_meta_nxt.is_sample = 1'b1;
      a_x_nxt = RB'(k_ext - CW'(1));
    end else if (k_ext == rx2) begin
      a_meta_nxt.is_last = 1'b1;
      a_x_nxt = close_r ? '0 : rx_r;
    end else begin
      a_meta_nxt.oor = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_meta_r <= a_meta_nxt;
      a_x_r    <= a_x_nxt;
    end
  end

  // stage b: square x
  logic            b_valid_r;
  meta_t           b_meta_r;
  logic [RB-1:0]   b_x_r;
  logic [2*RB-1:0] b_xsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_meta_r <= a_meta_r;
      b_x_r    <= a_x_r;
      b_xsq_r  <= a_x_r * a_x_r;
    end
  end

  // square-root chain, one root bit per cell
  logic            s_valid [0:SQ];
  meta_t           s_meta  [0:SQ];
  logic [RB-1:0]   s_x     [0:SQ];
  logic [SQ+1:0]   s_rem   [0:SQ];
  logic [SQ-1:0]   s_root  [0:SQ];
  logic [RADW-1:0] s_rad   [0:SQ];

  assign s_valid[0] = b_valid_r;
  assign s_meta[0]  = b_meta_r;
  assign s_x[0]     = b_x_r;
  assign s_rem[0]   = '0;
  assign s_root[0]  = '0;
  // radicand (rx^2 - x^2) scaled by the fraction bits; wraps only for non-samples
  assign s_rad[0]   = RADW'(rx_sq_r - b_xsq_r) << (2 * FRAC_BITS);

  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    evqg_sqrt_cell #(
      .SQ_W  (SQ),
      .RAD_W (RADW),
      .X_W   (RB)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (s_valid[i]),
      .meta_i  (s_meta[i]),
      .x_i     (s_x[i]),
      .rem_i   (s_rem[i]),
      .root_i  (s_root[i]),
      .rad_i   (s_rad[i]),
      .valid_o (s_valid[i+1]),
      .meta_o  (s_meta[i+1]),
      .x_o     (s_x[i+1]),
      .rem_o   (s_rem[i+1]),
      .root_o  (s_root[i+1]),
      .rad_o   (s_rad[i+1])
    );
  end

  // multiply by radius_y
  logic          m_valid_r;
  meta_t         m_meta_r;
  logic [RB-1:0] m_x_r;
  logic [PW-1:0] m_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= s_valid[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_meta_r <= s_meta[SQ];
      m_x_r    <= s_x[SQ];
      m_prod_r <= ry_r * s_root[SQ];
    end
  end

  // divider chain by radius_x; quotient fits SQ bits since root <= rx << FRAC_BITS
  logic          d_valid [0:SQ];
  meta_t         d_meta  [0:SQ];
  logic [RB-1:0] d_x     [0:SQ];
  logic [RB-1:0] d_rem   [0:SQ];
  logic [SQ-1:0] d_low   [0:SQ];
  logic [SQ-1:0] d_quot  [0:SQ];

  assign d_valid[0] = m_valid_r;
  assign d_meta[0]  = m_meta_r;
  assign d_x[0]     = m_x_r;
  assign d_rem[0]   = m_prod_r[PW-1 -: RB];
  assign d_low[0]   = m_prod_r[SQ-1:0];
  assign d_quot[0]  = '0;

  for (genvar j = 0; j < SQ; j++) begin : g_div
    evqg_div_cell #(
      .RB_W (RB),
      .Q_W  (SQ)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .divisor (rx_r),
      .valid_i (d_valid[j]),
      .meta_i  (d_meta[j]),
      .x_i     (d_x[j]),
      .rem_i   (d_rem[j]),
      .low_i   (d_low[j]),
      .quot_i  (d_quot[j]),
      .valid_o (d_valid[j+1]),
      .meta_o  (d_meta[j+1]),
      .x_o     (d_x[j+1]),
      .rem_o   (d_rem[j+1]),
      .low_o   (d_low[j+1]),
      .quot_o  (d_quot[j+1])
    );
  end

  // output register: zero y for non-samples or zero radius, then quadrant sign
  logic [YW-1:0] y_mag;
  logic [XW-1:0] x_mag;
  logic [XW-1:0] x_nxt;
  logic [YW-1:0] y_nxt;
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic          last_r, oor_r;

  assign y_mag = (d_meta[SQ].is_sample && (rx_r != '0)) ? YW'(d_quot[SQ]) : '0;
  assign x_mag = XW'(d_x[SQ]);
  assign x_nxt = quad_r ? (XW'(0) - x_mag) : x_mag;
  assign y_nxt = quad_r ? (YW'(0) - y_mag) : y_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      last_r <= d_meta[SQ].is_last;
      oor_r  <= d_meta[SQ].oor;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_x_coord      = x_r;
  assign out_y_fixed      = y_r;
  assign out_is_last      = last_r;
  assign out_out_of_range = oor_r;

`ifndef SYNTHESIS
  // stall only comes from a waiting result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // out-of-range vertices carry zero coordinates
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (out_x_coord == '0 && out_y_fixed == '0))
    else $error("out-of-range vertex with nonzero coordinates");

  // closing vertex is never out of range
  a_last_oor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_last && out_out_of_range))
    else $error("vertex flagged both last and out of range");

  // a held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_y_fixed) && $stable(out_x_coord)))
    else $error("stalled result changed");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the ellipse quadrant vertex generator against a local predictor
// ----------------------------------------------------------------------------
// index transactions go in under random idling and stalls. Each one's expected
// vertex is computed here from the current register settings and queued. A
// monitor compares every output transaction field by field with the oldest
// queued vertex. Registers change only while the chain is empty.
// ----------------------------------------------------------------------------
module tb;
  import evqg_pkg::*;

  localparam int RB = DEF_RADIUS_BITS;
  localparam int FB = DEF_FRAC_BITS;
  localparam int XW = RB + 1;
  localparam int YW = RB + FB + 1;
  // extra wait after the expected queue empties, as margin before register writes
  localparam int DRAIN_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          last;
    logic          oor;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_RADIUS_X;
  logic [RB-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [INDEX_W-1:0] in_vertex_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [RB:0] out_x_coord;
  logic signed [RB+FB:0] out_y_fixed;
  logic out_is_last;
  logic out_out_of_range;

  // shadow of the block's registers
  logic [RB-1:0] rx_q = 1, ry_q = 1;
  logic quad_q = 1'b0, close_q = 1'b0;

  vertex_t expected_vertices[$];
  int mismatches = 0;
  longint cycles = 0;
  bit idle_on = 1'b1;

  ellipse_quadrant_vertex_gen dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // floor square root, bit by bit
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic vertex_t vertex_for_index(logic [INDEX_W-1:0] k);
    longint unsigned x, y, rx, rad;
    vertex_t v;
    rx = rx_q;
    x = 0;
    y = 0;
    v = '0;
    if (k == 0) begin
      // origin
    end else if (k <= rx + 1) begin
      x = k - 1;
      if (rx != 0) begin
        rad = (rx * rx - x * x) << (2 * FB);
        y = (longint'(ry_q) * root_floor(rad)) / rx;
      end
    end else if (k == rx + 2) begin
      v.last = 1'b1;
      x = close_q ? 0 : rx;
    end else begin
      v.oor = 1'b1;
    end
    if (quad_q) begin
      x = -x;
      y = -y;
    end
    v.x = x[XW-1:0];
    v.y = y[YW-1:0];
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  // receiver stalls at random while idling is on
  always @(posedge clk) begin
    out_stall <= idle_on ? ($urandom_range(99) < 36) : 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    vertex_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_vertices.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        w = expected_vertices.pop_front();
        if (out_x_coord !== w.x) report_mismatch("x_coord", out_x_coord, w.x);
        if (out_y_fixed !== w.y) report_mismatch("y_fixed", out_y_fixed, w.y);
        if (out_is_last !== w.last) report_mismatch("is_last", out_is_last, w.last);
        if (out_out_of_range !== w.oor)
          report_mismatch("out_of_range", out_out_of_range, w.oor);
      end
    end
  end

  // in_valid stays high into the next transaction unless an idle cycle comes
  task automatic send_index(logic [INDEX_W-1:0] k);
    while (idle_on && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vertex_index <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_vertices.push_back(vertex_for_index(k));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // cfg_we is left high; the caller drops it after the last write
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [RB-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_RADIUS_X:     rx_q = val;
      CFG_RADIUS_Y:     ry_q = val;
      CFG_QUADRANT_SEL: quad_q = val[0];
      CFG_CLOSING_KIND: close_q = val[0];
      default: ;
    endcase
  endtask

  task automatic set_shape(logic [RB-1:0] rx, logic [RB-1:0] ry, bit quad, bit clos);
    drain();
    write_reg(CFG_RADIUS_X, rx);
    write_reg(CFG_RADIUS_Y, ry);
    write_reg(CFG_QUADRANT_SEL, RB'(quad));
    write_reg(CFG_CLOSING_KIND, RB'(clos));
    cfg_we <= 1'b0;
  endtask

  // reset values, then extremes of index and radius, both quadrants and closings
  task automatic test_directed;
    send_index(0);
    send_index(1);
    send_index(3);
    send_index(4);
    send_index(11'h7ff);
    set_shape(RB'(1023), RB'(1023), 1'b0, 1'b0);
    send_index(0);
    send_index(1);
    send_index(512);
    send_index(1024);
    send_index(1025);
    send_index(11'h7ff);
    set_shape(RB'(1023), RB'(1023), 1'b1, 1'b1);
    send_index(1);
    send_index(1024);
    send_index(1025);
    set_shape(RB'(0), RB'(5), 1'b0, 1'b0);
    send_index(0);
    send_index(1);
    send_index(2);
    send_index(3);
    set_shape(RB'(7), RB'(0), 1'b1, 1'b0);
    send_index(3);
    send_index(9);
  endtask

  // long run with no idling on either side
  task automatic test_back_to_back;
    set_shape(RB'(1023), RB'(700), 1'b0, 1'b1);
    idle_on = 1'b0;
    for (int k = 0; k < 300; k++) send_index(INDEX_W'(k * 3));
    idle_on = 1'b1;
  endtask

  // full index sweeps for small random shapes, random indices up to rx+3 for large ones, plus stray indices
  task automatic test_random_sweeps;
    int sent, rx;
    sent = 0;
    while (sent < 1500) begin
      rx = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(40);
      set_shape(RB'(rx), RB'($urandom_range(1023)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
      if (rx > 100) begin
        repeat (30) send_index(INDEX_W'($urandom_range(rx + 3)));
        sent += 30;
      end else begin
        for (int k = 0; k <= rx + 2; k++) send_index(INDEX_W'(k));
        sent += rx + 3;
      end
      repeat (5) send_index(INDEX_W'($urandom));
      sent += 5;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_back_to_back();
    test_random_sweeps();
    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/evqg_pkg.sv
rtl/evqg_sqrt_cell.sv
rtl/evqg_div_cell.sv
rtl/ellipse_quadrant_vertex_gen.sv
tb/sv/tb.sv
